// File: rtl/scl_pkg.sv
// Shared types and constants for the serial command line parser.
package scl_pkg;

	localparam int BYTE_W  = 8;
	localparam int ARG_W   = 7;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 3;
	localparam int BUF_LEN = 6;

	localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_AT  = 8'h40;

	typedef enum logic [3:0] {
		ACT_NONE       = 4'd0,
		ACT_ECHO       = 4'd1,
		ACT_PIN_READ   = 4'd2,
		ACT_PIN_SET    = 4'd3,
		ACT_PIN_CLEAR  = 4'd4,
		ACT_PORT_READ  = 4'd5,
		ACT_PORT_WRITE = 4'd6,
		ACT_LCD_CHAR   = 4'd7,
		ACT_CURSOR     = 4'd8,
		ACT_DATE       = 4'd9,
		ACT_TIME       = 4'd10,
		ACT_ERROR      = 4'd11
	} action_t;

	typedef logic [BUF_LEN-1:0][BYTE_W-1:0] fbuf_t;

	typedef struct packed {
		action_t             action;
		logic [ARG_W-1:0]    arg_a;
		logic [ARG_W-1:0]    arg_b;
		logic [ARG_W-1:0]    arg_c;
		logic [BYTE_W-1:0]   data_byte;
	} result_t;

	// Decoded argument fields and their checks; command families share fields such as port and dec0..dec2
	typedef struct packed {
		logic                port_ok;
		logic                pin_ok;
		logic                wr_ok;
		logic                cursor_ok;
		logic                date_ok;
		logic                time_ok;
		logic [ARG_W-1:0]    port;
		logic [ARG_W-1:0]    pin;
		logic [BYTE_W-1:0]   wr_byte;
		logic [ARG_W-1:0]    row;
		logic [ARG_W-1:0]    col;
		logic [ARG_W-1:0]    dec0;
		logic [ARG_W-1:0]    dec1;
		logic [ARG_W-1:0]    dec2;
	} args_t;

endpackage

// File: rtl/serial_command_line_parser_core.sv
// Top level of the serial command line parser: input register, parser, result register.
//
// Takes one received byte per word on the in channel and returns exactly one result
// word per byte on the out channel. A byte is registered on acceptance and decoded
// against the parser state into the result register once that register is empty or
// its word leaves, so one byte can be taken every cycle while out_ready is high.
// While a finished result waits to be taken, the input register can still take one
// more byte; after that in_ready stays low until the waiting result leaves.
// ESC resets the parser at once; CR is handled as LF. After reset the parser waits
// for a command byte; no setup is needed.
module serial_command_line_parser_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [scl_pkg::BYTE_W-1:0]        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [3:0]                        action,
	output logic [scl_pkg::ARG_W-1:0]         arg_a,
	output logic [scl_pkg::ARG_W-1:0]         arg_b,
	output logic [scl_pkg::ARG_W-1:0]         arg_c,
	output logic [scl_pkg::BYTE_W-1:0]        data_byte
);

	logic                       valid_s1, valid_s2;
	logic [scl_pkg::BYTE_W-1:0] rx_byte_s1;
	scl_pkg::result_t           res, result_s2;
	scl_pkg::fbuf_t             fbuf;
	scl_pkg::args_t             args;
	logic                       load_s2, in_take;

	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !load_s2);
			valid_s2 <= load_s2 || (valid_s2 && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rx_byte_s1 <= rx_byte;
		end
		if (load_s2) begin
			result_s2 <= res;
		end
	end

	scl_argchk u_argchk (
		.fbuf (fbuf),
		.args (args)
	);

	scl_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (load_s2),
		.rx_byte (rx_byte_s1),
		.args    (args),
		.fbuf    (fbuf),
		.res     (res)
	);

	assign out_valid = valid_s2;
	assign action    = result_s2.action;
	assign arg_a     = result_s2.arg_a;
	assign arg_b     = result_s2.arg_b;
	assign arg_c     = result_s2.arg_c;
	assign data_byte = result_s2.data_byte;

endmodule

// File: rtl/scl_argchk.sv
// Argument decode and range checks over the field buffer.
module scl_argchk (
	input  scl_pkg::fbuf_t fbuf,
	output scl_pkg::args_t args
);

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c inside {[8'h30:8'h39]}) || (c inside {[8'h61:8'h66]});
	endfunction

	// only meaningful when is_hex holds; 'a' has low nibble 1
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		hex_val = (c[6]) ? 4'(c[3:0] + 4'd9) : c[3:0];
	endfunction

	function automatic logic [6:0] dec_val(input logic [7:0] hi, input logic [7:0] lo);
		dec_val = 7'({hi[3:0], 3'b000}) + 7'({hi[3:0], 1'b0}) + 7'(lo[3:0]);
	endfunction

	logic       all_dig;
	logic [4:0] mdays;
	logic [6:0] yr, mon, day;

	always_comb begin
		all_dig = 1'b1;
		for (int i = 0; i < scl_pkg::BUF_LEN; i++) begin
			all_dig = all_dig & is_digit(fbuf[i]);
		end
	end

	assign yr  = dec_val(fbuf[0], fbuf[1]);
	assign mon = dec_val(fbuf[2], fbuf[3]);
	assign day = dec_val(fbuf[4], fbuf[5]);

	always_comb begin
		if (mon == 7'd2) begin
			mdays = (yr[1:0] == 2'b00) ? 5'd29 : 5'd28;
		end else if (mon == 7'd4 || mon == 7'd6 || mon == 7'd9 || mon == 7'd11) begin
			mdays = 5'd30;
		end else begin
			mdays = 5'd31;
		end
	end

	always_comb begin
		args.port_ok   = fbuf[0] inside {[8'h30:8'h33]};
		args.pin_ok    = fbuf[1] inside {[8'h30:8'h37]};
		args.wr_ok     = is_hex(fbuf[1]) && is_hex(fbuf[2]);
		args.cursor_ok = is_hex(fbuf[0]) && is_hex(fbuf[1]);
		args.date_ok   = all_dig && (mon != 7'd0) && (mon <= 7'd12)
			&& (day != 7'd0) && (day <= 7'(mdays));
		args.time_ok   = all_dig && (yr < 7'd24) && (mon < 7'd60) && (day < 7'd60);
		args.port      = 7'(fbuf[0][1:0]);
		args.pin       = 7'(fbuf[1][2:0]);
		args.wr_byte   = {hex_val(fbuf[1]), hex_val(fbuf[2])};
		args.row       = 7'(hex_val(fbuf[0]));
		args.col       = 7'(hex_val(fbuf[1]));
		args.dec0      = yr;
		args.dec1      = mon;
		args.dec2      = day;
	end

endmodule

// File: rtl/scl_seq.sv
// Command sequencer: parser state, field buffer and per-byte action decode.
module scl_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [scl_pkg::BYTE_W-1:0]    rx_byte,
	input  scl_pkg::args_t                args,
	output scl_pkg::fbuf_t                fbuf,
	output scl_pkg::result_t              res
);

	localparam logic [3:0] CMD_IDLE       = 4'd0;
	localparam logic [3:0] CMD_PIN_READ   = 4'd1;
	localparam logic [3:0] CMD_PIN_SET    = 4'd2;
	localparam logic [3:0] CMD_PIN_CLEAR  = 4'd3;
	localparam logic [3:0] CMD_PORT_READ  = 4'd4;
	localparam logic [3:0] CMD_PORT_WRITE = 4'd5;
	localparam logic [3:0] CMD_CURSOR     = 4'd6;
	localparam logic [3:0] CMD_LCD        = 4'd7;
	localparam logic [3:0] CMD_DATE       = 4'd8;
	localparam logic [3:0] CMD_TIME       = 4'd9;
	localparam logic [3:0] CMD_FAILED     = 4'd15;

	localparam logic [7:0] KEY_PIN_READ   = 8'h62; // b
	localparam logic [7:0] KEY_PIN_SET    = 8'h73; // s
	localparam logic [7:0] KEY_PIN_CLEAR  = 8'h63; // c
	localparam logic [7:0] KEY_PORT_READ  = 8'h70; // p
	localparam logic [7:0] KEY_PORT_WRITE = 8'h77; // w
	localparam logic [7:0] KEY_CURSOR     = 8'h6D; // m
	localparam logic [7:0] KEY_LCD        = 8'h6C; // l
	localparam logic [7:0] KEY_DATE       = 8'h64; // d
	localparam logic [7:0] KEY_TIME       = 8'h74; // t

	// bytes after each command letter, closing LF included; idle and LCD take one byte at a time
	function automatic logic [2:0] cmd_len(input logic [3:0] idx);
		case (idx)
			CMD_IDLE:       cmd_len = 3'd1;
			CMD_PIN_READ:   cmd_len = 3'd3;
			CMD_PIN_SET:    cmd_len = 3'd3;
			CMD_PIN_CLEAR:  cmd_len = 3'd3;
			CMD_PORT_READ:  cmd_len = 3'd2;
			CMD_PORT_WRITE: cmd_len = 3'd4;
			CMD_CURSOR:     cmd_len = 3'd3;
			CMD_LCD:        cmd_len = 3'd1;
			CMD_DATE:       cmd_len = 3'd7;
			CMD_TIME:       cmd_len = 3'd7;
			default:        cmd_len = 3'd0;
		endcase
	endfunction

	logic [3:0] idx_q, idx_d;
	logic [2:0] cnt_q, cnt_d, cnt_inc;
	scl_pkg::fbuf_t fbuf_q;
	logic [7:0] c;
	logic       wr_en;
	logic [2:0] wr_idx;
	logic       failed, run_fail;

	assign fbuf = fbuf_q;
	assign c = (rx_byte == scl_pkg::CH_CR) ? scl_pkg::CH_LF : rx_byte;
	assign cnt_inc = cnt_q + 3'd1;
	assign wr_idx = cnt_inc - 3'd1;

	always_comb begin
		res      = '0;
		idx_d    = idx_q;
		cnt_d    = cnt_q;
		wr_en    = 1'b0;
		failed   = 1'b0;
		run_fail = 1'b0;
		if (rx_byte == scl_pkg::CH_ESC) begin
			idx_d = CMD_IDLE;
			cnt_d = '0;
		end else begin
			if (idx_q > CMD_TIME) begin
				failed = 1'b1;
			end else begin
				cnt_d = cnt_inc;
				if (cnt_inc == cmd_len(idx_q)) begin
					if (idx_q == CMD_IDLE) begin
						cnt_d = '0;
						case (c)
							scl_pkg::CH_LF:  idx_d = CMD_IDLE;
							KEY_PIN_READ:    idx_d = CMD_PIN_READ;
							KEY_PIN_SET:     idx_d = CMD_PIN_SET;
							KEY_PIN_CLEAR:   idx_d = CMD_PIN_CLEAR;
							KEY_PORT_READ:   idx_d = CMD_PORT_READ;
							KEY_PORT_WRITE:  idx_d = CMD_PORT_WRITE;
							KEY_CURSOR:      idx_d = CMD_CURSOR;
							KEY_LCD:         idx_d = CMD_LCD;
							KEY_DATE:        idx_d = CMD_DATE;
							KEY_TIME:        idx_d = CMD_TIME;
							scl_pkg::CH_AT: begin
								res.action    = scl_pkg::ACT_ECHO;
								res.data_byte = scl_pkg::CH_AT;
							end
							default: begin
								cnt_d    = cnt_inc;
								run_fail = 1'b1;
							end
						endcase
					end else if (idx_q == CMD_LCD) begin
						cnt_d = '0;
						if (c == scl_pkg::CH_LF) begin
							idx_d = CMD_IDLE;
						end else begin
							res.action    = scl_pkg::ACT_LCD_CHAR;
							res.data_byte = c;
						end
					end else if (c != scl_pkg::CH_LF) begin
						run_fail = 1'b1;
					end else begin
						case (idx_q)
							CMD_PIN_READ, CMD_PIN_SET, CMD_PIN_CLEAR: begin
								run_fail = !(args.port_ok && args.pin_ok);
								res.action = (idx_q == CMD_PIN_READ) ? scl_pkg::ACT_PIN_READ :
									(idx_q == CMD_PIN_SET) ? scl_pkg::ACT_PIN_SET :
									scl_pkg::ACT_PIN_CLEAR;
								res.arg_a = args.port;
								res.arg_b = args.pin;
							end
							CMD_PORT_READ: begin
								run_fail   = !args.port_ok;
								res.action = scl_pkg::ACT_PORT_READ;
								res.arg_a  = args.port;
							end
							CMD_PORT_WRITE: begin
								run_fail      = !(args.port_ok && args.wr_ok);
								res.action    = scl_pkg::ACT_PORT_WRITE;
								res.arg_a     = args.port;
								res.data_byte = args.wr_byte;
							end
							CMD_CURSOR: begin
								run_fail   = !args.cursor_ok;
								res.action = scl_pkg::ACT_CURSOR;
								res.arg_a  = args.col;
								res.arg_b  = args.row;
							end
							CMD_DATE: begin
								run_fail   = !args.date_ok;
								res.action = scl_pkg::ACT_DATE;
								res.arg_a  = args.dec0;
								res.arg_b  = args.dec1;
								res.arg_c  = args.dec2;
							end
							CMD_TIME: begin
								run_fail   = !args.time_ok;
								res.action = scl_pkg::ACT_TIME;
								res.arg_a  = args.dec0;
								res.arg_b  = args.dec1;
								res.arg_c  = args.dec2;
							end
							default: run_fail = 1'b1;
						endcase
						if (!run_fail) begin
							idx_d = CMD_IDLE;
							cnt_d = '0;
						end
					end
					if (run_fail) begin
						res    = '0;
						idx_d  = CMD_FAILED;
						failed = 1'b1;
					end
				end else if (c == scl_pkg::CH_LF) begin
					failed = 1'b1;
				end else if (cnt_inc >= 3'd1 && cnt_inc <= 3'(scl_pkg::BUF_LEN)) begin
					wr_en = 1'b1;
				end
			end
			// a failed line reports once its LF arrives
			if (failed && c == scl_pkg::CH_LF) begin
				res        = '0;
				res.action = scl_pkg::ACT_ERROR;
				idx_d      = CMD_IDLE;
				cnt_d      = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= CMD_IDLE;
			cnt_q <= '0;
		end else if (step) begin
			idx_q <= idx_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < scl_pkg::BUF_LEN; i++) begin
			if (step && wr_en && wr_idx == 3'(i)) begin
				fbuf_q[i] <= c;
			end
		end
	end

endmodule

// File: rtl/scl_checker.sv
// Port-level assertions for the serial command line parser, bound to the top level.
module scl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [scl_pkg::BYTE_W-1:0]        rx_byte,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [3:0]                        action,
	input logic [scl_pkg::ARG_W-1:0]         arg_a,
	input logic [scl_pkg::ARG_W-1:0]         arg_b,
	input logic [scl_pkg::ARG_W-1:0]         arg_c,
	input logic [scl_pkg::BYTE_W-1:0]        data_byte
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(action) && $stable(arg_a)
			&& $stable(arg_b) && $stable(arg_c) && $stable(data_byte))
		else $error("result changed while stalled");

	// empty result register never blocks the input
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty result register");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> action <= scl_pkg::ACT_ERROR)
		else $error("action code out of range");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (action == scl_pkg::ACT_ERROR || action == scl_pkg::ACT_NONE)
			|-> arg_a == '0 && arg_b == '0 && arg_c == '0 && data_byte == '0)
		else $error("error or empty word carries arguments");

	a_echo: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == scl_pkg::ACT_ECHO |-> data_byte == scl_pkg::CH_AT
			&& arg_a == '0 && arg_b == '0 && arg_c == '0)
		else $error("echo word malformed");

endmodule

bind serial_command_line_parser_core scl_checker u_scl_checker (.*);
